/* hw/rtl/rmd160_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160_pkg
// constants, step tables and helper functions for the ripemd-160 engine
// ----------------------------------------------------------------------------
package rmd160_pkg;

  localparam int unsigned STEPS = 80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [0:79][3:0] SEL_L = {
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [0:79][3:0] SEL_R = {
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [0:79][4:0] ROT_L = {
    5'd11, 5'd14, 5'd15, 5'd12, 5'd5, 5'd8, 5'd7, 5'd9,
    5'd11, 5'd13, 5'd14, 5'd15, 5'd6, 5'd7, 5'd9, 5'd8,
    5'd7, 5'd6, 5'd8, 5'd13, 5'd11, 5'd9, 5'd7, 5'd15,
    5'd7, 5'd12, 5'd15, 5'd9, 5'd11, 5'd7, 5'd13, 5'd12,
    5'd11, 5'd13, 5'd6, 5'd7, 5'd14, 5'd9, 5'd13, 5'd15,
    5'd14, 5'd8, 5'd13, 5'd6, 5'd5, 5'd12, 5'd7, 5'd5,
    5'd11, 5'd12, 5'd14, 5'd15, 5'd14, 5'd15, 5'd9, 5'd8,
    5'd9, 5'd14, 5'd5, 5'd6, 5'd8, 5'd6, 5'd5, 5'd12,
    5'd9, 5'd15, 5'd5, 5'd11, 5'd6, 5'd8, 5'd13, 5'd12,
    5'd5, 5'd12, 5'd13, 5'd14, 5'd11, 5'd8, 5'd5, 5'd6};

  localparam logic [0:79][4:0] ROT_R = {
    5'd8, 5'd9, 5'd9, 5'd11, 5'd13, 5'd15, 5'd15, 5'd5,
    5'd7, 5'd7, 5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd6,
    5'd9, 5'd13, 5'd15, 5'd7, 5'd12, 5'd8, 5'd9, 5'd11,
    5'd7, 5'd7, 5'd12, 5'd7, 5'd6, 5'd15, 5'd13, 5'd11,
    5'd9, 5'd7, 5'd15, 5'd11, 5'd8, 5'd6, 5'd6, 5'd14,
    5'd12, 5'd13, 5'd5, 5'd14, 5'd13, 5'd13, 5'd7, 5'd5,
    5'd15, 5'd5, 5'd8, 5'd11, 5'd14, 5'd14, 5'd6, 5'd14,
    5'd6, 5'd9, 5'd12, 5'd9, 5'd12, 5'd5, 5'd15, 5'd8,
    5'd8, 5'd5, 5'd12, 5'd9, 5'd12, 5'd5, 5'd14, 5'd6,
    5'd8, 5'd13, 5'd6, 5'd5, 5'd15, 5'd13, 5'd11, 5'd11};

  localparam logic [0:4][31:0] ADD_L = {
    32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
  localparam logic [0:4][31:0] ADD_R = {
    32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};

  typedef logic [31:0] word_t;
  typedef word_t [4:0] line_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } digest_t;

  function automatic word_t rol(input word_t x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

  function automatic word_t boolfn(input logic [2:0] j, input word_t x, input word_t y,
                                   input word_t z);
    word_t r;
    case (j)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/rmd160_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160 channel interfaces
// valid/ready channels for message items and digest items
// ----------------------------------------------------------------------------
interface rmd160_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface rmd160_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                digest_word4, output ready);
endinterface

/* hw/rtl/rmd160_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd160_round
// one step of the left and right lines, shared over all 80 steps
// ----------------------------------------------------------------------------
module rmd160_round (
  input  logic [6:0]             step,
  input  rmd160_pkg::word_t      xl,
  input  rmd160_pkg::word_t      xr,
  input  rmd160_pkg::line_t      wl,
  input  rmd160_pkg::line_t      wr,
  output rmd160_pkg::line_t      wl_next,
  output rmd160_pkg::line_t      wr_next
);
  import rmd160_pkg::*;

  logic [2:0] rnd;
  word_t      tl, tr;

  assign rnd = step[6:4];

  assign tl = rol(wl[0] + boolfn(rnd, wl[1], wl[2], wl[3]) + xl + ADD_L[rnd],
                  ROT_L[step]) + wl[4];
  assign tr = rol(wr[0] + boolfn(3'd4 - rnd, wr[1], wr[2], wr[3]) + xr + ADD_R[rnd],
                  ROT_R[step]) + wr[4];

  assign wl_next = {wl[3], rol(wl[2], 5'd10), wl[1], tl, wl[4]};
  assign wr_next = {wr[3], rol(wr[2], 5'd10), wr[1], tr, wr[4]};
endmodule

/* hw/rtl/ripemd160_hash_top.sv */
`timescale 1ns / 1ps
// data byte: taken when idle; filling a 64-byte block starts 80 steps and fold
// end item: marker byte, padding bytes, then one compression per block,
// then the digest item is held until taken; no item is taken during compression
// the round datapath is one step of both lines per cycle
// reset (synchronous) restores the initial chaining words and zero length
// ----------------------------------------------------------------------------
// ripemd160_hash_top
// ripemd-160 digest engine: byte packing, padding, iterative compression
// ----------------------------------------------------------------------------
module ripemd160_hash_top (
  input logic        clk,
  input logic        rst,
  rmd160_in_if.sink  in_ch,
  rmd160_out_if.source out_ch
);
  import rmd160_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [6:0]  step;
  logic        padding;
  logic        tail_long;
  logic [63:0] byte_count;
  logic [63:0] bits;
  logic [5:0]  pos;
  word_t       blk [16];
  line_t       cv, wl, wr, wl_n, wr_n;
  word_t       xl, xr;
  logic [7:0]  wbyte;
  logic        wen;
  digest_t     dig;

  rmd160_round u_round (
    .step(step), .xl(xl), .xr(xr), .wl(wl), .wr(wr), .wl_next(wl_n), .wr_next(wr_n)
  );

  assign xl = blk[SEL_L[step]];
  assign xr = blk[SEL_R[step]];

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word0 = dig.w0;
  assign out_ch.digest_word1 = dig.w1;
  assign out_ch.digest_word2 = dig.w2;
  assign out_ch.digest_word3 = dig.w3;
  assign out_ch.digest_word4 = dig.w4;

  // byte for the current position: input data or marker, then zeros, then length
  always_comb begin
    wen = 1'b0;
    wbyte = in_ch.data_byte;
    if (state == S_IDLE && in_ch.valid) begin
      wen = 1'b1;
      wbyte = in_ch.kind ? 8'h80 : in_ch.data_byte;
    end else if (state == S_PAD) begin
      wen = 1'b1;
      // a long tail leaves the length for the extra block
      if (pos >= 6'd56 && !tail_long) wbyte = bits[8 * pos[2:0] +: 8];
      else wbyte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) blk[pos[5:2]][8 * pos[1:0] +: 8] <= wbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      padding <= 1'b0;
      tail_long <= 1'b0;
      byte_count <= '0;
      pos <= '0;
      cv <= {IV4, IV3, IV2, IV1, IV0};
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            pos <= pos + 6'd1;
            padding <= in_ch.kind;
            if (in_ch.kind) begin
              bits <= {byte_count[60:0], 3'b000};
              tail_long <= (pos >= 6'd56);
            end else begin
              byte_count <= byte_count + 64'd1;
            end
            if (pos == 6'd63) begin
              state <= S_COMP;
              step <= '0;
              wl <= cv;
              wr <= cv;
            end else if (in_ch.kind) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            state <= S_COMP;
            step <= '0;
            wl <= cv;
            wr <= cv;
          end
        end
        S_COMP: begin
          wl <= wl_n;
          wr <= wr_n;
          if (step == 7'(STEPS - 1)) begin
            state <= S_FOLD;
            step <= '0;
          end else begin
            step <= step + 7'd1;
          end
        end
        S_FOLD: begin
          cv[0] <= cv[1] + wl[2] + wr[3];
          cv[1] <= cv[2] + wl[3] + wr[4];
          cv[2] <= cv[3] + wl[4] + wr[0];
          cv[3] <= cv[4] + wl[0] + wr[1];
          cv[4] <= cv[0] + wl[1] + wr[2];
          if (!padding) begin
            state <= S_IDLE;
          end else if (tail_long) begin
            // a tail too long for the length field needs one more block
            tail_long <= 1'b0;
            state <= S_PAD;
          end else begin
            state <= S_OUT;
          end
          dig <= {cv[1] + wl[2] + wr[3], cv[2] + wl[3] + wr[4], cv[3] + wl[4] + wr[0],
                  cv[4] + wl[0] + wr[1], cv[0] + wl[1] + wr[2]};
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state <= S_IDLE;
            byte_count <= '0;
            pos <= '0;
            padding <= 1'b0;
            tail_long <= 1'b0;
            cv <= {IV4, IV3, IV2, IV1, IV0};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
